/* sv/event_expiry_scheduler_unit_macros.svh */
// ----------------------------------------------------------------------------
// event expiry scheduler assertion macros
// shared concurrent assertion forms for the scheduler rtl
// ----------------------------------------------------------------------------
`ifndef EVENT_EXPIRY_SCHEDULER_UNIT_MACROS_SVH
`define EVENT_EXPIRY_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication
`define EESU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EESU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/eesu_pkg.sv */
// ----------------------------------------------------------------------------
// eesu_pkg
// shared constants, codes and types of the event expiry scheduler
// ----------------------------------------------------------------------------
package eesu_pkg;

    localparam int EVENT_COUNT     = 17;
    localparam int FIRST_CPU_BASE  = 6;
    localparam int SECOND_CPU_BASE = 11;
    localparam int MAX_FIRE        = 6;
    localparam int FIRE_CNT_W      = 3;

    localparam logic [15:0] LOOKAHEAD_RST = 16'd64;

    localparam logic [2:0] OP_SCHED_ABS   = 3'd0;
    localparam logic [2:0] OP_RESCHED     = 3'd1;
    localparam logic [2:0] OP_SCHED_CPU   = 3'd2;
    localparam logic [2:0] OP_CANCEL      = 3'd3;
    localparam logic [2:0] OP_QUERY       = 3'd4;
    localparam logic [2:0] OP_RUN_GROUP   = 3'd5;

    localparam logic [1:0] GRP_SYS  = 2'd0;
    localparam logic [1:0] GRP_CPU0 = 2'd1;
    localparam logic [1:0] GRP_CPU1 = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [4:0]  event_id;
        logic        cpu_select;
        logic [63:0] time_value;
        logic [63:0] cpu_time;
        logic [63:0] cpu_target;
        logic        all_idle;
        logic [1:0]  event_group;
    } t_item;

    typedef struct packed {
        logic [63:0] time_out;
        logic        target_lowered;
        logic        fired;
        logic [4:0]  fired_id;
        logic [63:0] lateness;
        logic        query_error;
    } t_result;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ram_ctl;

endpackage

/* sv/event_expiry_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// event_expiry_scheduler_unit
// discrete event scheduler: per-event enable flag and 64-bit expiry time.
// s_axis carries one operation per transfer (tuser = operation code);
// m_axis returns its results, tlast on the final one of each operation.
// schedule, reschedule and cancel give no result; schedule after cpu and
// query give one; run group gives one per fired event, up to six.
// the config channel writes the 16-bit lookahead; write it only when idle.
// one operation is in flight at a time. every scan walks the slots through the
// single expiry memory read port, one slot a cycle unless a fired result stalls.
// each result is registered in the output register on its way to m_axis.
// reset disables all events, makes every expiry read as zero and sets lookahead to 64.
// a stalled m_axis holds the output register; the sequencer waits on it.
// ----------------------------------------------------------------------------
module event_expiry_scheduler_unit #(
    parameter int EVENT_COUNT     = eesu_pkg::EVENT_COUNT,
    parameter int FIRST_CPU_BASE  = eesu_pkg::FIRST_CPU_BASE,
    parameter int SECOND_CPU_BASE = eesu_pkg::SECOND_CPU_BASE
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // event_id, cpu_select, time_value, cpu_time, cpu_target, all_idle,
    // event_group, zero pad
    input  logic [207:0]  s_axis_tdata,
    // operation
    input  logic [2:0]    s_axis_tuser,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [15:0]   i_cfg_data,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // time_out, target_lowered, fired_id, lateness, query_error, zero pad
    output logic [135:0]  m_axis_tdata,
    // fired
    output logic [0:0]    m_axis_tuser,
    output logic          m_axis_tlast
);

    localparam int IDX_W = $clog2(EVENT_COUNT);

    eesu_pkg::t_item    w_item;
    eesu_pkg::t_result  w_res;
    logic               w_res_last;
    logic               w_res_valid;
    logic               w_res_ready;
    eesu_pkg::t_result  w_out;
    logic               w_out_last;
    eesu_pkg::t_ram_ctl w_ram_ctl;
    logic [IDX_W-1:0]   w_wr_addr;
    logic [63:0]        w_wr_data;
    logic [IDX_W-1:0]   w_rd_addr;
    logic [63:0]        w_rd_data;

    assign w_item.operation   = s_axis_tuser;
    assign w_item.event_id    = s_axis_tdata[4:0];
    assign w_item.cpu_select  = s_axis_tdata[5];
    assign w_item.time_value  = s_axis_tdata[69:6];
    assign w_item.cpu_time    = s_axis_tdata[133:70];
    assign w_item.cpu_target  = s_axis_tdata[197:134];
    assign w_item.all_idle    = s_axis_tdata[198];
    assign w_item.event_group = s_axis_tdata[200:199];

    eesu_ctrl #(
        .EVENT_COUNT     (EVENT_COUNT),
        .FIRST_CPU_BASE  (FIRST_CPU_BASE),
        .SECOND_CPU_BASE (SECOND_CPU_BASE),
        .IDX_W           (IDX_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_in          (w_item),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_res         (w_res),
        .o_res_last    (w_res_last),
        .o_ram_ctl     (w_ram_ctl),
        .o_ram_wr_addr (w_wr_addr),
        .o_ram_wr_data (w_wr_data),
        .o_ram_rd_addr (w_rd_addr),
        .i_ram_rd_data (w_rd_data)
    );

    eesu_expiry_ram #(
        .DEPTH (EVENT_COUNT),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_ctl     (w_ram_ctl),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    eesu_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .o_ready (w_res_ready),
        .i_res   (w_res),
        .i_last  (w_res_last),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_out),
        .o_last  (w_out_last)
    );

    assign m_axis_tdata[63:0]    = w_out.time_out;
    assign m_axis_tdata[64]      = w_out.target_lowered;
    assign m_axis_tdata[69:65]   = w_out.fired_id;
    assign m_axis_tdata[133:70]  = w_out.lateness;
    assign m_axis_tdata[134]     = w_out.query_error;
    assign m_axis_tdata[135]     = 1'b0;
    assign m_axis_tuser[0]       = w_out.fired;
    assign m_axis_tlast          = w_out_last;

endmodule

/* sv/eesu_expiry_ram.sv */
// ----------------------------------------------------------------------------
// eesu_expiry_ram
// expiry time storage, one write and one registered read port
// ----------------------------------------------------------------------------
module eesu_expiry_ram #(
    parameter int DEPTH = eesu_pkg::EVENT_COUNT,
    parameter int AW    = $clog2(eesu_pkg::EVENT_COUNT)
) (
    input  logic                i_clk,
    input  eesu_pkg::t_ram_ctl  i_ctl,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [63:0]         i_wr_data,
    input  logic [AW-1:0]       i_rd_addr,
    output logic [63:0]         o_rd_data
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/eesu_ctrl.sv */
// ----------------------------------------------------------------------------
// eesu_ctrl
// operation sequencer: enable flags, expiry read-modify-write and slot scans
// ----------------------------------------------------------------------------
`include "event_expiry_scheduler_unit_macros.svh"

module eesu_ctrl #(
    parameter int EVENT_COUNT     = eesu_pkg::EVENT_COUNT,
    parameter int FIRST_CPU_BASE  = eesu_pkg::FIRST_CPU_BASE,
    parameter int SECOND_CPU_BASE = eesu_pkg::SECOND_CPU_BASE,
    parameter int IDX_W           = $clog2(eesu_pkg::EVENT_COUNT)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  eesu_pkg::t_item     i_in,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output eesu_pkg::t_result   o_res,
    output logic                o_res_last,
    output eesu_pkg::t_ram_ctl  o_ram_ctl,
    output logic [IDX_W-1:0]    o_ram_wr_addr,
    output logic [63:0]         o_ram_wr_data,
    output logic [IDX_W-1:0]    o_ram_rd_addr,
    input  logic [63:0]         i_ram_rd_data
);

    localparam int CNT_W = $clog2(EVENT_COUNT + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
    localparam int FW    = eesu_pkg::FIRE_CNT_W;

    localparam int LO_C0 = (FIRST_CPU_BASE < EVENT_COUNT) ? FIRST_CPU_BASE : EVENT_COUNT;
    localparam int LO_C1 = (SECOND_CPU_BASE < EVENT_COUNT) ? SECOND_CPU_BASE : EVENT_COUNT;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_RMW  = 3'd2;
    localparam logic [2:0] ST_CMP2 = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_QFIN = 3'd5;
    localparam logic [2:0] ST_QERR = 3'd6;
    localparam logic [2:0] ST_EMIT = 3'd7;

    logic [2:0]             r_state, n_state;
    eesu_pkg::t_item        r_item, n_item;
    logic [15:0]            r_lookahead;
    logic [EVENT_COUNT-1:0] r_enabled, n_enabled;
    logic [EVENT_COUNT-1:0] r_written, n_written;
    logic [CNT_W-1:0]       r_addr, n_addr;
    logic [CNT_W-1:0]       r_hi, n_hi;
    logic                   r_proc_vld, n_proc_vld;
    logic [IDX_W-1:0]       r_proc_idx, n_proc_idx;
    logic [63:0]            r_sum, n_sum;
    logic [63:0]            r_best, n_best;
    logic [FW-1:0]          r_count, n_count;
    eesu_pkg::t_result      r_pend, n_pend;
    logic                   r_pend_vld, n_pend_vld;

    logic                   w_id_ok;
    logic [IDX_W-1:0]       w_id_idx;
    logic [63:0]            w_rd_exp;
    logic                   w_is_query;
    logic                   w_hit;
    logic                   w_stall;
    logic                   w_fire_take;
    logic [63:0]            w_tgt_sh;
    logic                   w_lowered;

    assign w_id_ok    = CMP_W'(r_item.event_id) < CMP_W'(EVENT_COUNT);
    assign w_id_idx   = IDX_W'(r_item.event_id);
    assign w_rd_exp   = r_written[r_proc_idx] ? i_ram_rd_data : 64'd0;
    assign w_is_query = (r_item.operation == eesu_pkg::OP_QUERY);
    assign w_hit      = (r_state == ST_SCAN) && r_proc_vld && r_enabled[r_proc_idx]
                        && (w_is_query ? (w_rd_exp < r_best) : (r_sum >= w_rd_exp));
    assign w_stall    = !w_is_query && w_hit && r_pend_vld && !i_res_ready;
    assign w_fire_take = !w_is_query && w_hit && !w_stall;
    assign w_tgt_sh   = r_item.cpu_target << r_item.cpu_select;
    assign w_lowered  = r_sum < w_tgt_sh;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res       = r_pend;
    assign o_res_last  = (r_state == ST_EMIT);

    always_comb begin
        n_state       = r_state;
        n_item        = r_item;
        n_enabled     = r_enabled;
        n_written     = r_written;
        n_addr        = r_addr;
        n_hi          = r_hi;
        n_proc_vld    = r_proc_vld;
        n_proc_idx    = r_proc_idx;
        n_sum         = r_sum;
        n_best        = r_best;
        n_count       = r_count;
        n_pend        = r_pend;
        n_pend_vld    = r_pend_vld;
        o_ram_ctl     = '0;
        o_ram_wr_addr = w_id_idx;
        o_ram_wr_data = r_item.time_value;
        o_ram_rd_addr = w_id_idx;
        o_res_valid   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_IDLE;
                case (r_item.operation)
                    eesu_pkg::OP_SCHED_ABS: begin
                        if (w_id_ok) begin
                            o_ram_ctl.wr_en     = 1'b1;
                            n_enabled[w_id_idx] = 1'b1;
                            n_written[w_id_idx] = 1'b1;
                        end
                    end
                    eesu_pkg::OP_RESCHED: begin
                        if (w_id_ok) begin
                            o_ram_ctl.rd_en = 1'b1;
                            n_proc_idx      = w_id_idx;
                            n_state         = ST_RMW;
                        end
                    end
                    eesu_pkg::OP_SCHED_CPU: begin
                        n_sum   = (r_item.cpu_time << r_item.cpu_select) + r_item.time_value;
                        n_state = ST_CMP2;
                    end
                    eesu_pkg::OP_CANCEL: begin
                        if (w_id_ok) begin
                            n_enabled[w_id_idx] = 1'b0;
                        end
                    end
                    eesu_pkg::OP_QUERY: begin
                        n_sum      = r_item.cpu_time + {48'd0, r_lookahead};
                        n_addr     = '0;
                        n_hi       = CNT_W'(EVENT_COUNT);
                        n_proc_vld = 1'b0;
                        n_best     = '1;
                        n_state    = ST_SCAN;
                    end
                    eesu_pkg::OP_RUN_GROUP: begin
                        n_count    = '0;
                        n_pend_vld = 1'b0;
                        n_proc_vld = 1'b0;
                        case (r_item.event_group)
                            eesu_pkg::GRP_SYS: begin
                                n_addr  = '0;
                                n_hi    = CNT_W'(LO_C0);
                                n_sum   = r_item.cpu_time;
                                n_state = ST_SCAN;
                            end
                            eesu_pkg::GRP_CPU0: begin
                                n_addr  = CNT_W'(LO_C0);
                                n_hi    = CNT_W'(LO_C1);
                                n_sum   = r_item.cpu_time;
                                n_state = ST_SCAN;
                            end
                            eesu_pkg::GRP_CPU1: begin
                                n_addr  = CNT_W'(LO_C1);
                                n_hi    = CNT_W'(EVENT_COUNT);
                                n_sum   = r_item.cpu_time << 1;
                                n_state = ST_SCAN;
                            end
                            default: begin
                                n_state = ST_IDLE;
                            end
                        endcase
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_RMW: begin
                o_ram_ctl.wr_en       = 1'b1;
                o_ram_wr_addr         = r_proc_idx;
                o_ram_wr_data         = w_rd_exp + r_item.time_value;
                n_enabled[r_proc_idx] = 1'b1;
                n_written[r_proc_idx] = 1'b1;
                n_state               = ST_IDLE;
            end
            ST_CMP2: begin
                n_pend                = '0;
                n_pend.time_out       = w_lowered ? (r_sum >> r_item.cpu_select)
                                                  : r_item.cpu_target;
                n_pend.target_lowered = w_lowered;
                if (w_id_ok) begin
                    o_ram_ctl.wr_en     = 1'b1;
                    o_ram_wr_data       = r_sum;
                    n_enabled[w_id_idx] = 1'b1;
                    n_written[w_id_idx] = 1'b1;
                end
                n_state = ST_EMIT;
            end
            ST_SCAN: begin
                o_res_valid   = !w_is_query && w_hit && r_pend_vld;
                o_ram_rd_addr = r_addr[IDX_W-1:0];
                if (!w_stall) begin
                    if (w_hit && w_is_query) begin
                        n_best = w_rd_exp;
                    end
                    if (w_fire_take) begin
                        n_enabled[r_proc_idx] = 1'b0;
                        n_pend                = '0;
                        n_pend.fired          = 1'b1;
                        n_pend.fired_id       = 5'(r_proc_idx);
                        n_pend.lateness       = r_sum - w_rd_exp;
                        n_pend_vld            = 1'b1;
                        n_count               = r_count + FW'(1);
                    end
                    if (r_addr < r_hi) begin
                        o_ram_ctl.rd_en = 1'b1;
                        n_proc_idx      = r_addr[IDX_W-1:0];
                        n_proc_vld      = 1'b1;
                        n_addr          = r_addr + CNT_W'(1);
                    end else begin
                        n_proc_vld = 1'b0;
                    end
                    if (w_fire_take && (r_count == FW'(eesu_pkg::MAX_FIRE - 1))) begin
                        n_proc_vld = 1'b0;
                        n_state    = ST_EMIT;
                    end else if (r_addr >= r_hi) begin
                        if (w_is_query) begin
                            n_state = ST_QFIN;
                        end else if (n_pend_vld) begin
                            n_state = ST_EMIT;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_QFIN: begin
                if (!r_item.all_idle && (r_sum < r_best)) begin
                    n_best = r_sum;
                end
                n_state = ST_QERR;
            end
            ST_QERR: begin
                n_pend             = '0;
                n_pend.time_out    = r_best;
                n_pend.query_error = (r_best <= r_item.cpu_time);
                n_state            = ST_EMIT;
            end
            ST_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_pend_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lookahead <= eesu_pkg::LOOKAHEAD_RST;
            r_enabled   <= '0;
            r_written   <= '0;
            r_proc_vld  <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state    <= n_state;
            r_enabled  <= n_enabled;
            r_written  <= n_written;
            r_proc_vld <= n_proc_vld;
            r_pend_vld <= n_pend_vld;
            r_count    <= n_count;
            if (i_cfg_valid) begin
                r_lookahead <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_addr     <= n_addr;
        r_hi       <= n_hi;
        r_proc_idx <= n_proc_idx;
        r_sum      <= n_sum;
        r_best     <= n_best;
        r_pend     <= n_pend;
    end

    `EESU_ASSERT_IMP(a_fire_limit, i_clk, i_rst_n, 1'b1, r_count <= FW'(eesu_pkg::MAX_FIRE), "fire count above limit")
    `EESU_ASSERT_NXT(a_fire_clears, i_clk, i_rst_n, w_fire_take, !r_enabled[$past(r_proc_idx)], "fired event still enabled")
    `EESU_ASSERT_NXT(a_emit_hold, i_clk, i_rst_n, (r_state == ST_EMIT) && !i_res_ready, r_state == ST_EMIT, "result dropped under stall")
    `EESU_ASSERT_IMP(a_idle_empty, i_clk, i_rst_n, r_state == ST_IDLE, !r_pend_vld, "pending result left at idle")

endmodule

/* sv/eesu_out_reg.sv */
// ----------------------------------------------------------------------------
// eesu_out_reg
// one-entry output register between sequencer and result stream
// ----------------------------------------------------------------------------
module eesu_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  eesu_pkg::t_result  i_res,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_ready,
    output eesu_pkg::t_result  o_res,
    output logic               o_last
);

    logic              r_full;
    eesu_pkg::t_result r_res;
    logic              r_last;

    assign o_ready = !r_full || i_ready;
    assign o_valid = r_full;
    assign o_res   = r_res;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_full <= 1'b1;
        end else if (i_ready) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_res  <= i_res;
            r_last <= i_last;
        end
    end

endmodule

/* verif/event_expiry_scheduler_unit_tb.sv */
// ----------------------------------------------------------------------------
// event_expiry_scheduler_unit_tb
// self-checking bench for the event expiry scheduler. operations go in over
// s_axis with random gaps, results come back over m_axis with random stalls.
// a predictor keeps its own copy of the event slots and the lookahead, and
// every result is compared field by field against the oldest prediction.
// the run covers the directed corner cases, several lookahead settings, a
// long output stall, a drained pause and time values that wrap at 2^64.
// ----------------------------------------------------------------------------
module event_expiry_scheduler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_UNUSED_A = 3'd6;
    localparam logic [2:0] OP_UNUSED_B = 3'd7;
    localparam logic [1:0] GRP_UNUSED  = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;

    typedef struct {
        eesu_pkg::t_result res;
        logic              last;
    } t_sched_outcome;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [207:0]   s_axis_tdata;
    logic [2:0]     s_axis_tuser;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [15:0]    i_cfg_data;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [135:0]   m_axis_tdata;
    logic [0:0]     m_axis_tuser;
    logic           m_axis_tlast;

    // predictor state
    logic [63:0]    slot_time [eesu_pkg::EVENT_COUNT];
    logic           slot_on [eesu_pkg::EVENT_COUNT];
    logic [15:0]    sched_lookahead;
    logic [63:0]    clock_base;
    t_sched_outcome pending_results[$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold_requests = 0;
    int rx_holds_done = 0;
    int fail_count = 0;
    int ops_sent = 0;
    int results_checked = 0;
    int events_fired = 0;
    int cfg_writes = 0;

    event_expiry_scheduler_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic eesu_pkg::t_item make_op(logic [2:0] op, logic [4:0] id, logic cpu,
                                                logic [63:0] tv, logic [63:0] now,
                                                logic [63:0] target, logic idle,
                                                logic [1:0] grp);
        eesu_pkg::t_item it;
        it.operation   = op;
        it.event_id    = id;
        it.cpu_select  = cpu;
        it.time_value  = tv;
        it.cpu_time    = now;
        it.cpu_target  = target;
        it.all_idle    = idle;
        it.event_group = grp;
        return it;
    endfunction

    function automatic void predict_item(eesu_pkg::t_item it);
        eesu_pkg::t_result outs[$];
        eesu_pkg::t_result r;
        t_sched_outcome    o;
        logic [63:0]       t;
        logic [63:0]       cap;
        logic [63:0]       cur;
        int                lo;
        int                hi;
        bit                id_ok;
        id_ok = it.event_id < eesu_pkg::EVENT_COUNT;
        r = '0;
        case (it.operation)
            eesu_pkg::OP_SCHED_ABS: begin
                if (id_ok) begin
                    slot_time[it.event_id] = it.time_value;
                    slot_on[it.event_id]   = 1'b1;
                end
            end
            eesu_pkg::OP_RESCHED: begin
                if (id_ok) begin
                    slot_time[it.event_id] = slot_time[it.event_id] + it.time_value;
                    slot_on[it.event_id]   = 1'b1;
                end
            end
            eesu_pkg::OP_SCHED_CPU: begin
                t = (it.cpu_time << it.cpu_select) + it.time_value;
                r.time_out = it.cpu_target;
                if (t < (it.cpu_target << it.cpu_select)) begin
                    r.time_out       = t >> it.cpu_select;
                    r.target_lowered = 1'b1;
                end
                if (id_ok) begin
                    slot_time[it.event_id] = t;
                    slot_on[it.event_id]   = 1'b1;
                end
                outs.push_back(r);
            end
            eesu_pkg::OP_CANCEL: begin
                if (id_ok) slot_on[it.event_id] = 1'b0;
            end
            eesu_pkg::OP_QUERY: begin
                r.time_out = '1;
                cap = it.cpu_time + {48'd0, sched_lookahead};
                for (int i = 0; i < eesu_pkg::EVENT_COUNT; i++) begin
                    if (slot_on[i] && slot_time[i] < r.time_out) r.time_out = slot_time[i];
                end
                if (!it.all_idle && cap < r.time_out) r.time_out = cap;
                r.query_error = r.time_out <= it.cpu_time;
                outs.push_back(r);
            end
            eesu_pkg::OP_RUN_GROUP: begin
                if (it.event_group != GRP_UNUSED) begin
                    cur = it.cpu_time;
                    if (it.event_group == eesu_pkg::GRP_SYS) begin
                        lo = 0;
                        hi = eesu_pkg::FIRST_CPU_BASE;
                    end else if (it.event_group == eesu_pkg::GRP_CPU0) begin
                        lo = eesu_pkg::FIRST_CPU_BASE;
                        hi = eesu_pkg::SECOND_CPU_BASE;
                    end else begin
                        lo = eesu_pkg::SECOND_CPU_BASE;
                        hi = eesu_pkg::EVENT_COUNT;
                        cur = it.cpu_time << 1;
                    end
                    for (int i = lo; i < hi && outs.size() < eesu_pkg::MAX_FIRE; i++) begin
                        if (slot_on[i] && cur >= slot_time[i]) begin
                            slot_on[i] = 1'b0;
                            r = '0;
                            r.fired    = 1'b1;
                            r.fired_id = 5'(i);
                            r.lateness = cur - slot_time[i];
                            outs.push_back(r);
                        end
                    end
                end
            end
            default: ;
        endcase
        foreach (outs[k]) begin
            o.res  = outs[k];
            o.last = (k == outs.size() - 1);
            pending_results.push_back(o);
        end
    endfunction

    function automatic logic [63:0] wide_pick(logic [63:0] v);
        return ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : v;
    endfunction

    function automatic eesu_pkg::t_item random_item();
        eesu_pkg::t_item it;
        int              pick;
        pick = $urandom_range(0, 99);
        clock_base = clock_base + $urandom_range(0, 40);
        if (pick < 20)      it.operation = eesu_pkg::OP_SCHED_ABS;
        else if (pick < 30) it.operation = eesu_pkg::OP_RESCHED;
        else if (pick < 45) it.operation = eesu_pkg::OP_SCHED_CPU;
        else if (pick < 53) it.operation = eesu_pkg::OP_CANCEL;
        else if (pick < 68) it.operation = eesu_pkg::OP_QUERY;
        else if (pick < 95) it.operation = eesu_pkg::OP_RUN_GROUP;
        else                it.operation = $urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B;
        it.event_id    = ($urandom_range(0, 19) == 0)
                         ? 5'($urandom_range(eesu_pkg::EVENT_COUNT, 31))
                         : 5'($urandom_range(0, eesu_pkg::EVENT_COUNT - 1));
        it.cpu_select  = 1'($urandom_range(0, 1));
        it.all_idle    = ($urandom_range(0, 3) == 0);
        it.event_group = ($urandom_range(0, 19) == 0) ? GRP_UNUSED : 2'($urandom_range(0, 2));
        it.cpu_time    = clock_base + $urandom_range(0, 60);
        it.cpu_target  = clock_base + $urandom_range(0, 300);
        if (it.operation == eesu_pkg::OP_SCHED_ABS) begin
            it.time_value = wide_pick(clock_base + $urandom_range(0, 150));
        end else begin
            it.time_value = wide_pick(64'($urandom_range(0, 100)));
        end
        // second cpu runs at half rate, its times are in its own cycles
        if ((it.operation == eesu_pkg::OP_SCHED_CPU && it.cpu_select) ||
            (it.operation == eesu_pkg::OP_RUN_GROUP && it.event_group == eesu_pkg::GRP_CPU1)) begin
            it.cpu_time   = it.cpu_time >> 1;
            it.cpu_target = it.cpu_target >> 1;
        end
        it.cpu_time   = wide_pick(it.cpu_time);
        it.cpu_target = wide_pick(it.cpu_target);
        return it;
    endfunction

    // called at a rising edge, returns at the edge of the transfer
    task automatic send_op(eesu_pkg::t_item it);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.operation;
        s_axis_tdata  <= {7'd0, it.event_group, it.all_idle, it.cpu_target, it.cpu_time,
                          it.time_value, it.cpu_select, it.event_id};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(it);
        ops_sent++;
    endtask

    task automatic send_random(int count);
        repeat (count) send_op(random_item());
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_lookahead(logic [15:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sched_lookahead = value;
        cfg_writes++;
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_sched_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_checked++;
            if (m_axis_tuser[0]) events_fired++;
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: tdata %h tuser %b", m_axis_tdata,
                       m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("time_out", want.res.time_out, m_axis_tdata[63:0]);
                check_field("target_lowered", 64'(want.res.target_lowered),
                            64'(m_axis_tdata[64]));
                check_field("fired", 64'(want.res.fired), 64'(m_axis_tuser[0]));
                check_field("fired_id", 64'(want.res.fired_id), 64'(m_axis_tdata[69:65]));
                check_field("lateness", want.res.lateness, m_axis_tdata[133:70]);
                check_field("query_error", 64'(want.res.query_error),
                            64'(m_axis_tdata[134]));
                check_field("last", 64'(want.last), 64'(m_axis_tlast));
            end
        end
    end

    initial begin : result_sink
        int w;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (rx_hold_requests != rx_holds_done) begin
                rx_holds_done = rx_hold_requests;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            w = rx_idle_on ? $urandom_range(0, 19) : 0;
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic test_directed_ops();
        logic [63:0] all1;
        all1 = '1;
        send_op(make_op(eesu_pkg::OP_SCHED_ABS, 5'd0, 1'b0, 64'd100, 64'd0, 64'd0, 1'b0,
                        eesu_pkg::GRP_SYS));
        send_op(make_op(eesu_pkg::OP_SCHED_ABS, 5'd16, 1'b0, all1, 64'd0, 64'd0, 1'b0,
                        eesu_pkg::GRP_SYS));
        send_op(make_op(eesu_pkg::OP_SCHED_ABS, 5'd5, 1'b0, 64'd0, 64'd0, 64'd0, 1'b0,
                        eesu_pkg::GRP_SYS));
        send_op(make_op(eesu_pkg::OP_RESCHED, 5'd0, 1'b0, 64'd50, 64'd0, 64'd0, 1'b0,
                        eesu_pkg::GRP_SYS));
        // reschedule of a disabled slot enables it
        send_op(make_op(eesu_pkg::OP_RESCHED, 5'd3, 1'b0, all1, 64'd0, 64'd0, 1'b0,
                        eesu_pkg::GRP_SYS));
        send_op(make_op(eesu_pkg::OP_SCHED_CPU, 5'd7, 1'b1, 64'd10, 64'd100, 64'd1000, 1'b0,
                        eesu_pkg::GRP_SYS));
        // out of range id still reports the target
        send_op(make_op(eesu_pkg::OP_SCHED_CPU, 5'd20, 1'b0, 64'd5, 64'd0, 64'd0, 1'b0,
                        eesu_pkg::GRP_SYS));
        send_op(make_op(eesu_pkg::OP_SCHED_CPU, 5'd8, 1'b0, all1, all1, all1, 1'b1,
                        eesu_pkg::GRP_CPU1));
        send_op(make_op(eesu_pkg::OP_QUERY, 5'd0, 1'b0, 64'd0, 64'd0, 64'd0, 1'b0,
                        eesu_pkg::GRP_SYS));
        send_op(make_op(eesu_pkg::OP_QUERY, 5'd0, 1'b0, 64'd0, 64'd200, 64'd0, 1'b1,
                        eesu_pkg::GRP_SYS));
        send_op(make_op(eesu_pkg::OP_CANCEL, 5'd16, 1'b0, 64'd0, 64'd0, 64'd0, 1'b0,
                        eesu_pkg::GRP_SYS));
        send_op(make_op(eesu_pkg::OP_CANCEL, 5'd31, 1'b0, 64'd0, 64'd0, 64'd0, 1'b0,
                        eesu_pkg::GRP_SYS));
        send_op(make_op(eesu_pkg::OP_SCHED_ABS, 5'd31, 1'b1, 64'd5, 64'd0, 64'd0, 1'b1,
                        GRP_UNUSED));
        send_op(make_op(eesu_pkg::OP_RUN_GROUP, 5'd0, 1'b0, 64'd0, 64'd200, 64'd0, 1'b0,
                        eesu_pkg::GRP_SYS));
        send_op(make_op(eesu_pkg::OP_RUN_GROUP, 5'd0, 1'b0, 64'd0, 64'd300, 64'd0, 1'b0,
                        eesu_pkg::GRP_CPU0));
        send_op(make_op(eesu_pkg::OP_RUN_GROUP, 5'd0, 1'b0, 64'd0, all1, 64'd0, 1'b0,
                        GRP_UNUSED));
        send_op(make_op(OP_UNUSED_A, 5'd1, 1'b0, 64'd0, 64'd0, 64'd0, 1'b0,
                        eesu_pkg::GRP_SYS));
        send_op(make_op(OP_UNUSED_B, 5'd2, 1'b1, all1, all1, all1, 1'b1,
                        eesu_pkg::GRP_CPU1));
        // fill the second cpu group, then fire all of it in one run
        for (int i = eesu_pkg::SECOND_CPU_BASE; i < eesu_pkg::EVENT_COUNT; i++) begin
            send_op(make_op(eesu_pkg::OP_SCHED_ABS, 5'(i), 1'b0, 64'(1000 + i), 64'd0, 64'd0,
                            1'b0, eesu_pkg::GRP_SYS));
        end
        send_op(make_op(eesu_pkg::OP_RUN_GROUP, 5'd0, 1'b0, 64'd0, 64'd600, 64'd0, 1'b0,
                        eesu_pkg::GRP_CPU1));
    endtask

    task automatic test_lookahead_settings();
        logic [15:0] settings[4];
        settings[0] = 16'd1;
        settings[1] = 16'hFFFF;
        settings[2] = 16'd0;
        settings[3] = 16'($urandom_range(2, 65534));
        foreach (settings[k]) begin
            write_lookahead(settings[k]);
            send_random(25);
        end
    endtask

    task automatic test_output_backpressure();
        eesu_pkg::t_item it;
        write_lookahead(eesu_pkg::LOOKAHEAD_RST);
        rx_hold_requests++;
        tx_idle_on = 1'b0;
        for (int k = 0; k < 24; k++) begin
            it = random_item();
            it.operation = (k % 3 == 0) ? eesu_pkg::OP_SCHED_CPU : eesu_pkg::OP_QUERY;
            send_op(it);
        end
        tx_idle_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        send_random(20);
        wait_drained();
        send_random(20);
    endtask

    task automatic test_time_wrap();
        write_lookahead(16'd300);
        clock_base = 64'hFFFF_FFFF_FFFF_FE00;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random(40);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        sched_lookahead = eesu_pkg::LOOKAHEAD_RST;
        clock_base    = {32'd0, $urandom};
        foreach (slot_on[i]) begin
            slot_on[i]   = 1'b0;
            slot_time[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_ops();
        test_lookahead_settings();
        test_output_backpressure();
        test_drain_pause();
        test_time_wrap();
        wait_drained();
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        $display("run covered %0d operations, %0d results checked, %0d events fired,",
                 ops_sent, results_checked, events_fired);
        $display("%0d lookahead writes, a long output stall and wrapping time values",
                 cfg_writes);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
